// ----- rtl/core/ppu_pkg.sv -----
// ppu_pkg: shared constants, types and helpers for the packed pixel unpacker.
// No dependencies; imported by every module in rtl/core.
`timescale 1ns / 1ps

package ppu_pkg;

  localparam int LANES      = 8;
  localparam int LANE_IW    = 3;
  localparam int PIX_W      = 13;
  localparam int ORIGIN_W   = 12;
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 3'd5;

  localparam logic [1:0] DEPTH_1 = 2'd0;
  localparam logic [1:0] DEPTH_2 = 2'd1;
  localparam logic [1:0] DEPTH_4 = 2'd2;
  localparam logic [1:0] DEPTH_8 = 2'd3;

  typedef struct packed {
    logic       hit;
    logic [7:0] color;
  } lane_res_t;

  // x / 255 for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

// ----- rtl/core/ppu_lane.sv -----
// ppu_lane: one pixel slot of a byte - level extract, scale, brightness product.
// Depends on ppu_pkg.
`timescale 1ns / 1ps

module ppu_lane
  import ppu_pkg::*;
#(
  parameter int LANE = 0,
  parameter int XW   = 13,
  parameter int WW   = 11
) (
  input  logic          clk,
  input  logic          load,
  input  logic [7:0]    data_byte,
  input  logic [1:0]    depth_log2,
  input  logic [7:0]    brightness,
  input  logic [XW-1:0] x_base,
  input  logic [WW-1:0] width,
  output lane_res_t     res
);

  localparam int I2 = LANE % 4;
  localparam int I4 = LANE % 2;

  logic [7:0]  level_c;
  logic [15:0] prod_nxt;
  logic [15:0] prod_r;
  logic        act_nxt;
  logic        act_r;
  logic [XW-1:0] x;
  logic [3:0]  ppb;
  logic [7:0]  q;

  always_comb begin
    case (depth_log2)
      DEPTH_1: level_c = {8{data_byte[7-(LANE%8)]}};
      DEPTH_2: level_c = {4{data_byte[7-2*I2 -: 2]}};
      DEPTH_4: level_c = {2{data_byte[7-4*I4 -: 4]}};
      DEPTH_8: level_c = data_byte;
      default: level_c = data_byte;
    endcase
  end

  assign ppb      = 4'd8 >> depth_log2;
  assign x        = x_base + XW'(LANE);
  assign act_nxt  = (4'(LANE) < ppb) && (x < XW'(width));
  assign prod_nxt = level_c * brightness;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
      act_r  <= act_nxt;
    end
  end

  assign q         = div255(prod_r);
  assign res.hit   = act_r && (q != 8'd0);
  assign res.color = q;

endmodule

// ----- rtl/core/ppu_merge.sv -----
// ppu_merge: collects the lane results of one byte and issues hits one per cycle
// while out_stall is low. Depends on ppu_pkg; fed by the ppu_lane instances.
`timescale 1ns / 1ps

module ppu_merge
  import ppu_pkg::*;
#(
  parameter int XW = 13,
  parameter int RW = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_valid,
  input  logic [XW-1:0]               s1_base,
  input  logic [RW-1:0]               s1_row,
  input  lane_res_t [LANES-1:0]       lane_res,
  input  logic [ORIGIN_W-1:0]         origin_x,
  input  logic [ORIGIN_W-1:0]         origin_y,
  output logic                        s1_free,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [PIX_W-1:0]     out_pixel_x,
  output logic signed [PIX_W-1:0]     out_pixel_y,
  output logic [7:0]                  out_color,
  output logic                        out_last_of_byte
);

  localparam int SX = (XW > PIX_W) ? XW : PIX_W;
  localparam int SY = (RW > PIX_W) ? RW : PIX_W;

  logic [LANES-1:0] mask_r, mask_nxt, new_mask, low_bit;
  logic [7:0]       color_r [LANES];
  logic [XW-1:0]    base_r;
  logic [RW-1:0]    row_r;
  logic [LANE_IW-1:0] idx;
  logic             has, out_load, buf_load;
  logic [SX-1:0]    x_sum;
  logic [SY-1:0]    y_sum;

  logic                    out_valid_r;
  logic [PIX_W-1:0]        pixel_x_r, pixel_y_r;
  logic [7:0]              color_out_r;
  logic                    last_r;

  always_comb begin
    idx = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (mask_r[i]) idx = LANE_IW'(i);
    end
    for (int i = 0; i < LANES; i++) new_mask[i] = lane_res[i].hit;
  end

  assign low_bit  = LANES'(1) << idx;
  assign has      = (mask_r != '0);
  assign out_load = has && (!out_valid_r || !out_stall);
  assign s1_free  = !has || ((mask_r == low_bit) && out_load);
  assign buf_load = s1_valid && s1_free;

  always_comb begin
    mask_nxt = mask_r;
    if (buf_load) begin
      mask_nxt = new_mask;
    end else if (out_load) begin
      mask_nxt = mask_r & ~low_bit;
    end
  end

  assign x_sum = SX'(signed'(origin_x)) + SX'(base_r) + SX'(idx);
  assign y_sum = SY'(signed'(origin_y)) + SY'(row_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (buf_load) begin
      base_r <= s1_base;
      row_r  <= s1_row;
      for (int i = 0; i < LANES; i++) color_r[i] <= lane_res[i].color;
    end
    if (out_load) begin
      pixel_x_r   <= x_sum[PIX_W-1:0];
      pixel_y_r   <= y_sum[PIX_W-1:0];
      color_out_r <= color_r[idx];
      last_r      <= (mask_r == low_bit);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = signed'(pixel_x_r);
  assign out_pixel_y      = signed'(pixel_y_r);
  assign out_color        = color_out_r;
  assign out_last_of_byte = last_r;

endmodule

// ----- rtl/core/packed_pixel_unpacker.sv -----
// packed_pixel_unpacker: top level - config registers, row/column position, eight
// pixel lanes and the result merger. Depends on ppu_pkg, ppu_lane, ppu_merge.
// Path: an accepted byte is registered in the lanes and s1 registers, then in the
// merger's buffer, then in the output register. Throughput: one pixel per cycle on
// the output while out_stall is low; the input stalls while the merger still holds
// pixels of an earlier byte, limited by the single-pixel output register it feeds.
// Reset: synchronous active-low; position, pipeline valids and config to defaults.
`timescale 1ns / 1ps

module packed_pixel_unpacker
  import ppu_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_data_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [PIX_W-1:0] out_pixel_x,
  output logic signed [PIX_W-1:0] out_pixel_y,
  output logic [7:0]              out_color,
  output logic                    out_last_of_byte,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int XW = CW + 3;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int KW = (WW + 1 > CW + 1) ? WW + 1 : CW + 1;
  localparam int JW = (HW > RW + 1) ? HW : RW + 1;

  logic [ORIGIN_W-1:0] origin_x_r, origin_y_r;
  logic [DIM_W-1:0]    width_cfg_r, height_cfg_r;
  logic [1:0]          depth_r;
  logic [7:0]          brightness_r;

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          s1_valid_r;
  logic [XW-1:0] s1_base_r;
  logic [RW-1:0] s1_row_r;

  logic [WW-1:0] width;
  logic [HW-1:0] height;
  logic [KW-1:0] cols;
  logic          row_end, frame_end, accept, s1_free;
  logic [XW-1:0] x_base;
  lane_res_t [LANES-1:0] lane_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      width_cfg_r  <= DIM_W'(1);
      height_cfg_r <= DIM_W'(1);
      depth_r      <= DEPTH_1;
      brightness_r <= 8'd255;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ORIGIN_X:   origin_x_r   <= cfg_data[ORIGIN_W-1:0];
        CFG_ORIGIN_Y:   origin_y_r   <= cfg_data[ORIGIN_W-1:0];
        CFG_WIDTH:      width_cfg_r  <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT:     height_cfg_r <= cfg_data[DIM_W-1:0];
        CFG_DEPTH:      depth_r      <= cfg_data[1:0];
        CFG_BRIGHTNESS: brightness_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // effective geometry: zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (width_cfg_r == '0) begin
      width = WW'(1);
    end else if (32'(width_cfg_r) > MAX_WIDTH) begin
      width = WW'(MAX_WIDTH);
    end else begin
      width = WW'(width_cfg_r);
    end
    if (height_cfg_r == '0) begin
      height = HW'(1);
    end else if (32'(height_cfg_r) > MAX_HEIGHT) begin
      height = HW'(MAX_HEIGHT);
    end else begin
      height = HW'(height_cfg_r);
    end
  end

  assign cols      = (KW'(width) + (KW'(8 >> depth_r) - KW'(1))) >> (2'd3 - depth_r);
  assign row_end   = (KW'(col_r) + KW'(1)) >= cols;
  assign frame_end = (JW'(row_r) + JW'(1)) >= JW'(height);
  assign x_base    = XW'(col_r) << (2'd3 - depth_r);

  assign in_stall = s1_valid_r && !s1_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        if (row_end) begin
          col_r <= '0;
          row_r <= frame_end ? '0 : row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end else if (s1_free) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_base_r <= x_base;
      s1_row_r  <= row_r;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    ppu_lane #(
      .LANE (g),
      .XW   (XW),
      .WW   (WW)
    ) u_lane (
      .clk        (clk),
      .load       (accept),
      .data_byte  (in_data_byte),
      .depth_log2 (depth_r),
      .brightness (brightness_r),
      .x_base     (x_base),
      .width      (width),
      .res        (lane_res[g])
    );
  end

  ppu_merge #(
    .XW (XW),
    .RW (RW)
  ) u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .s1_valid         (s1_valid_r),
    .s1_base          (s1_base_r),
    .s1_row           (s1_row_r),
    .lane_res         (lane_res),
    .origin_x         (origin_x_r),
    .origin_y         (origin_y_r),
    .s1_free          (s1_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_color        (out_color),
    .out_last_of_byte (out_last_of_byte)
  );

endmodule

// ----- tb/packed_pixel_unpacker_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for packed_pixel_unpacker: tracks config writes and the row/column position,
// predicts the pixels each accepted byte yields and compares every result transaction.
// Depends on ppu_pkg.

module packed_pixel_unpacker_checker
  import ppu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [7:0]              in_data_byte,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [PIX_W-1:0] out_pixel_x,
  input  logic signed [PIX_W-1:0] out_pixel_y,
  input  logic [7:0]              out_color,
  input  logic                    out_last_of_byte,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output int                      fail_count,
  output int                      pixels_pending
);

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic [7:0]       color;
    logic             last;
  } pixel_t;

  pixel_t pixels_due[$];

  logic [ORIGIN_W-1:0] org_x, org_y;
  logic [DIM_W-1:0]    img_w, img_h;
  logic [1:0]          depth;
  logic [7:0]          bright;
  int                  col_pos, row_pos;
  int                  fails = 0;

  function automatic int clamp_dim(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic unpack_byte(input logic [7:0] b);
    pixel_t found[8];
    pixel_t p;
    int     bpp, ppb, maxlev, w, h, cols, x, lev, c2, n;
    case (depth)
      DEPTH_1: bpp = 1;
      DEPTH_2: bpp = 2;
      DEPTH_4: bpp = 4;
      default: bpp = 8;
    endcase
    ppb    = 8 / bpp;
    maxlev = (1 << bpp) - 1;
    w      = clamp_dim(int'(img_w), DEF_MAX_WIDTH);
    h      = clamp_dim(int'(img_h), DEF_MAX_HEIGHT);
    cols   = (w + ppb - 1) / ppb;
    n      = 0;
    for (int i = 0; i < ppb; i++) begin
      x   = col_pos * ppb + i;
      lev = (int'(b) >> (8 - (i + 1) * bpp)) & maxlev;
      c2  = ((lev * 255) / maxlev) * int'(bright) / 255;
      // padding past the row width and dark pixels give nothing
      if (x < w && c2 != 0) begin
        p.x     = PIX_W'(int'($signed(org_x)) + x);
        p.y     = PIX_W'(int'($signed(org_y)) + row_pos);
        p.color = c2[7:0];
        p.last  = 1'b0;
        found[n] = p;
        n++;
      end
    end
    if (n > 0) found[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) pixels_due.push_back(found[k]);

    // a column or row already past a shrunk geometry simply ends the row / frame
    if (col_pos + 1 >= cols) begin
      col_pos = 0;
      if (row_pos + 1 >= h) row_pos = 0;
      else row_pos++;
    end else begin
      col_pos++;
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      org_x   = '0;
      org_y   = '0;
      img_w   = DIM_W'(1);
      img_h   = DIM_W'(1);
      depth   = DEPTH_1;
      bright  = 8'd255;
      col_pos = 0;
      row_pos = 0;
      pixels_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ORIGIN_X:   org_x  = cfg_data[ORIGIN_W-1:0];
          CFG_ORIGIN_Y:   org_y  = cfg_data[ORIGIN_W-1:0];
          CFG_WIDTH:      img_w  = cfg_data[DIM_W-1:0];
          CFG_HEIGHT:     img_h  = cfg_data[DIM_W-1:0];
          CFG_DEPTH:      depth  = cfg_data[1:0];
          CFG_BRIGHTNESS: bright = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) unpack_byte(in_data_byte);
      if (out_valid && !out_stall) begin
        if (pixels_due.size() == 0) begin
          $error("pixel transaction with none expected: x %0d y %0d color %0d",
                 out_pixel_x, out_pixel_y, out_color);
          fails++;
        end else begin
          want = pixels_due.pop_front();
          if (out_pixel_x !== want.x) begin
            $error("pixel_x: expected %0d, got %0d", $signed(want.x), out_pixel_x);
            fails++;
          end
          if (out_pixel_y !== want.y) begin
            $error("pixel_y: expected %0d, got %0d", $signed(want.y), out_pixel_y);
            fails++;
          end
          if (out_color !== want.color) begin
            $error("color: expected %0d, got %0d", want.color, out_color);
            fails++;
          end
          if (out_last_of_byte !== want.last) begin
            $error("last_of_byte: expected %0d, got %0d", want.last, out_last_of_byte);
            fails++;
          end
        end
      end
    end
    pixels_pending <= pixels_due.size();
    fail_count     <= fails;
  end

endmodule

// ----- tb/packed_pixel_unpacker_test.sv -----
`timescale 1ns / 1ps
// Top of the packed_pixel_unpacker testbench: clock, reset, byte and config stimulus,
// receiver stalls and the verdict. Depends on ppu_pkg, the unpacker and its checker.

module packed_pixel_unpacker_test;
  import ppu_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASES        = 9;
  localparam int PHASE_BYTES   = 40;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [7:0]              in_data_byte = 8'd0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [PIX_W-1:0] out_pixel_x, out_pixel_y;
  logic [7:0]              out_color;
  logic                    out_last_of_byte;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  int fail_count, pixels_pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;

  always #2 clk = ~clk;

  packed_pixel_unpacker uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pixel_x(out_pixel_x), .out_pixel_y(out_pixel_y),
    .out_color(out_color), .out_last_of_byte(out_last_of_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  packed_pixel_unpacker_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pixel_x(out_pixel_x), .out_pixel_y(out_pixel_y),
    .out_color(out_color), .out_last_of_byte(out_last_of_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pixels_pending(pixels_pending)
  );

  // receiver: random stalls, or a long hold-off counted down here
  always @(posedge clk) begin
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len = hold_len - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // cfg_valid is left high; the caller drops it after the last write
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_all(input logic [11:0] ox, input logic [11:0] oy,
                             input logic [11:0] w, input logic [11:0] h,
                             input logic [1:0] d, input logic [7:0] b);
    cfg_write(CFG_ORIGIN_X, ox);
    cfg_write(CFG_ORIGIN_Y, oy);
    cfg_write(CFG_WIDTH, w);
    cfg_write(CFG_HEIGHT, h);
    cfg_write(CFG_DEPTH, CFG_DATA_W'(d));
    cfg_write(CFG_BRIGHTNESS, CFG_DATA_W'(b));
    cfg_valid <= 1'b0;
  endtask

  task automatic put_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pixels_pending != 0);
  endtask

  // drained, then long enough for a dark byte still in the pipe to retire
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [11:0] val;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: one pixel per frame, second byte is dark there, rest padding
    put_byte(8'h80);
    put_byte(8'h7F);
    settle();

    // origin extremes, 1 bpp, dark byte between lit ones
    program_all(12'h800, 12'h7FF, 12'd8, 12'd2, DEPTH_1, 8'd255);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'hA5);
    settle();

    // 2 bpp, odd width so the last byte of a row is part padding
    program_all(12'h000, 12'h000, 12'd5, 12'd3, DEPTH_2, 8'd127);
    put_byte(8'hE4);
    put_byte(8'h1B);
    put_byte(8'hFF);
    settle();

    // 4 bpp at brightness 1: only full level survives; then brightness zero
    program_all(12'h7FF, 12'hFFF, 12'd3, 12'd2, DEPTH_4, 8'd1);
    put_byte(8'hF1);
    put_byte(8'h0F);
    settle();
    cfg_write(CFG_BRIGHTNESS, 12'd0);
    cfg_valid <= 1'b0;
    put_byte(8'hFF);
    settle();

    // 8 bpp, zero width acts as one, oversized height clamps; spare indexes ignored
    program_all(12'd5, 12'd9, 12'd0, 12'h7FF, DEPTH_8, 8'd200);
    cfg_write(CFG_SPARE_LO, 12'hABC);
    cfg_write(CFG_SPARE_HI, 12'h5A5);
    cfg_valid <= 1'b0;
    put_byte(8'hFF);
    put_byte(8'h01);
    put_byte(8'h00);
    settle();

    // geometry shrunk mid-row and mid-frame
    program_all(12'h000, 12'h000, 12'd64, 12'd4, DEPTH_1, 8'd255);
    put_byte(8'hC3);
    put_byte(8'h3C);
    put_byte(8'h81);
    settle();
    cfg_write(CFG_WIDTH, 12'd8);
    cfg_valid <= 1'b0;
    put_byte(8'hFF);
    put_byte(8'hAA);
    put_byte(8'h55);
    settle();
    cfg_write(CFG_HEIGHT, 12'd2);
    cfg_valid <= 1'b0;
    put_byte(8'hFF);
    put_byte(8'h81);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(3))
          0:       val = 12'h800;
          1:       val = 12'h7FF;
          default: val = 12'($urandom_range(4095));
        endcase
        cfg_write(CFG_ORIGIN_X, val);
      end
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(3))
          0:       val = 12'h800;
          1:       val = 12'h7FF;
          default: val = 12'($urandom_range(4095));
        endcase
        cfg_write(CFG_ORIGIN_Y, val);
      end
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(7))
          0:       val = 12'd0;
          1:       val = 12'd1024;
          2:       val = 12'($urandom_range(4095, 1025));
          default: val = 12'($urandom_range(40, 1));
        endcase
        cfg_write(CFG_WIDTH, val);
      end
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(7))
          0:       val = 12'd0;
          1:       val = 12'd1024;
          2:       val = 12'($urandom_range(4095, 1025));
          default: val = 12'($urandom_range(6, 1));
        endcase
        cfg_write(CFG_HEIGHT, val);
      end
      if ($urandom_range(3) != 0) cfg_write(CFG_DEPTH, 12'($urandom_range(3)));
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(5))
          0:       val = 12'd0;
          1:       val = 12'd255;
          2:       val = 12'd1;
          default: val = 12'($urandom_range(255));
        endcase
        cfg_write(CFG_BRIGHTNESS, val);
      end
      if ($urandom_range(3) == 0) cfg_write(CFG_SPARE_LO + 3'($urandom_range(1)),
                                            12'($urandom_range(4095)));
      // the hold-off phase needs plenty of pixels to back the block up
      if (ph == 2) begin
        cfg_write(CFG_DEPTH, 12'(DEPTH_1));
        cfg_write(CFG_BRIGHTNESS, 12'd255);
        cfg_write(CFG_WIDTH, 12'd1024);
      end
      cfg_valid <= 1'b0;

      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 59; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 6;  stall_pct = 6;  end
      endcase
      if (ph == 2) begin
        stall_pct = 0;
        hold_len  = 300;
      end

      for (int k = 0; k < PHASE_BYTES; k++) begin
        if (ph == 5 && k == PHASE_BYTES / 2) wait_drained();
        put_byte(8'($urandom_range(255)));
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("PASS packed_pixel_unpacker");
    end else begin
      $display("FAIL packed_pixel_unpacker");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAIL packed_pixel_unpacker");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ppu_pkg.sv
rtl/core/ppu_lane.sv
rtl/core/ppu_merge.sv
rtl/core/packed_pixel_unpacker.sv
tb/packed_pixel_unpacker_checker.sv
tb/packed_pixel_unpacker_test.sv
